// ----- rtl/core/rff_pkg.sv -----
// Shared types, widths, codes and the rounded fixed-point multiply for the
// relative permeability / fractional flow core. No dependencies.
package rff_pkg;

  localparam int FRAC_BITS = 15;
  localparam int FX_W      = FRAC_BITS + 1;
  localparam int VISC_W    = 16;
  localparam int VISC_FRAC = 8;
  localparam int MOB_W     = 24;
  localparam int PROD_W    = FX_W + VISC_W;
  localparam int DEN_W     = PROD_W + 1;
  localparam int MNUM_W    = FX_W + VISC_FRAC;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  localparam logic [FX_W-1:0]     ONE     = FX_W'(1) << FRAC_BITS;
  localparam logic [2*FX_W-1:0]   HALF    = (2*FX_W)'(1) << (FRAC_BITS - 1);
  localparam logic [MOB_W-1:0]    MOB_MAX = {MOB_W{1'b1}};
  localparam logic [VISC_W-1:0]   VISC_ONE = VISC_W'(1) << VISC_FRAC;

  localparam logic [CFG_IDX_W-1:0] CFG_PERM_MODEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RES_WATER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RES_OIL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VISC_WATER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VISC_OIL   = 3'd4;

  typedef enum logic [1:0] {
    MODEL_LINEAR  = 2'd0,
    MODEL_QUAD    = 2'd1,
    MODEL_COREY   = 2'd2,
    MODEL_QUARTIC = 2'd3
  } perm_model_t;

  typedef enum logic [1:0] {
    SE_ZERO = 2'd0,
    SE_ONE  = 2'd1,
    SE_DIV  = 2'd2
  } se_sel_t;

  typedef struct packed {
    perm_model_t        model;
    logic [FX_W-1:0]    rw;
    logic [FX_W-1:0]    ro;
    logic [VISC_W-1:0]  mw;
    logic [VISC_W-1:0]  mo;
  } cfg_t;

  typedef struct packed {
    perm_model_t     model;
    logic            clip;
    logic            undef;
    se_sel_t         se_sel;
    logic [FX_W-1:0] s;
    logic [FX_W-1:0] c;
    logic [FX_W-1:0] sq_s;
    logic [FX_W-1:0] sq_c;
    logic [FX_W-1:0] se_num;
    logic [FX_W-1:0] span;
  } front_t;

  typedef struct packed {
    logic [FX_W-1:0]   krw;
    logic [FX_W-1:0]   kro;
    logic [PROD_W-1:0] nw;
    logic [PROD_W-1:0] no;
    logic [MNUM_W-1:0] mnw;
    logic [MNUM_W-1:0] mno;
    logic              undef;
    logic              clip;
  } mid_t;

  typedef struct packed {
    logic [FX_W-1:0]   krw;
    logic [FX_W-1:0]   kro;
    logic [PROD_W-1:0] nw;
    logic              undef;
    logic              clip;
  } mobs_t;

  typedef struct packed {
    logic [FX_W-1:0] krw;
    logic [FX_W-1:0] kro;
  } kr_t;

  typedef struct packed {
    logic [MOB_W-1:0] mob;
    logic             undef;
    logic             clip;
  } tail_t;

  function automatic logic [FX_W-1:0] fx_mul(input logic [FX_W-1:0] a,
                                             input logic [FX_W-1:0] b);
    logic [2*FX_W-1:0] p;
    p = (2*FX_W)'(a) * (2*FX_W)'(b) + HALF;
    return p[FRAC_BITS +: FX_W];
  endfunction

endpackage

// ----- rtl/core/relperm_fractional_flow_core.sv -----
// Top level of the relative permeability / fractional flow core: config
// registers, pipeline control and output word. Depends on rff_pkg and all rff_* units.
//
// Takes one saturation word per cycle and returns one result word per cycle
// while the output is not stalled. The path runs through 1 input stage, 17
// normalized-saturation divider stages, 2 permeability stages, 24 mobility
// divider stages, 1 sum stage, 17 fractional-flow divider stages and 1 output
// register, most in the bit-per-stage dividers. A stalled output holds the whole pipe.
module relperm_fractional_flow_core import rff_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FX_W-1:0]      in_saturation,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [FX_W-1:0]      out_water_relperm,
  output logic [FX_W-1:0]      out_oil_relperm,
  output logic [MOB_W-1:0]     out_total_mobility,
  output logic [FX_W-1:0]      out_water_flow_fraction,
  output logic [FX_W-1:0]      out_oil_flow_fraction,
  output logic                 out_undefined_flag,
  output logic                 out_clipped_flag
);

  localparam int FRONT_W = $bits(front_t);
  localparam int MOBS_W  = $bits(mobs_t);
  localparam int KR_W    = $bits(kr_t);
  localparam int TAIL_W  = $bits(tail_t);

  cfg_t              cfg_r;
  logic              en;

  logic              fr_valid;
  front_t            fr_data;
  logic              se_valid;
  logic [FX_W-1:0]   se_q;
  logic [FRONT_W-1:0] se_side;
  logic              pm_valid;
  mid_t              pm_data;

  logic              ma_valid;
  logic              mb_valid;
  logic [MNUM_W-1:0] ma_q;
  logic [MNUM_W-1:0] mb_q;
  logic [MOBS_W-1:0] ma_side;
  logic [PROD_W-1:0] mb_side;
  mobs_t             ma_s;
  mobs_t             ma_d;

  logic              mx_valid_r;
  logic [DEN_W-1:0]  mx_den_r;
  logic [DEN_W-1:0]  mx_nw_r;
  logic [DEN_W-1:0]  mx_no_r;
  kr_t               mx_kr_r;
  tail_t             mx_tail_r;
  logic [MNUM_W:0]   mob_sum;
  tail_t             tail_nxt;

  logic              ra_valid;
  logic              rb_valid;
  logic [FX_W-1:0]   ra_q;
  logic [FX_W-1:0]   rb_q;
  logic [KR_W-1:0]   ra_side;
  logic [TAIL_W-1:0] rb_side;
  kr_t               ra_s;
  tail_t             rb_s;

  logic              out_valid_r;
  logic [FX_W-1:0]   out_krw_r;
  logic [FX_W-1:0]   out_kro_r;
  logic [MOB_W-1:0]  out_mob_r;
  logic [FX_W-1:0]   out_fw_r;
  logic [FX_W-1:0]   out_fo_r;
  logic              out_undef_r;
  logic              out_clip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.model <= MODEL_LINEAR;
      cfg_r.rw    <= '0;
      cfg_r.ro    <= '0;
      cfg_r.mw    <= VISC_ONE;
      cfg_r.mo    <= VISC_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PERM_MODEL: cfg_r.model <= perm_model_t'(cfg_data[1:0]);
        CFG_RES_WATER:  cfg_r.rw    <= cfg_data[FX_W-1:0];
        CFG_RES_OIL:    cfg_r.ro    <= cfg_data[FX_W-1:0];
        CFG_VISC_WATER: cfg_r.mw    <= (cfg_data == '0) ? VISC_W'(1) : cfg_data;
        CFG_VISC_OIL:   cfg_r.mo    <= (cfg_data == '0) ? VISC_W'(1) : cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  rff_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .saturation (in_saturation),
    .cfg        (cfg_r),
    .out_valid  (fr_valid),
    .out_data   (fr_data)
  );

  rff_ratio_div #(.DW(FX_W), .SW(FRONT_W)) u_se_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .num       (fr_data.se_num),
    .den       (fr_data.span),
    .side      (fr_data),
    .out_valid (se_valid),
    .quo       (se_q),
    .side_out  (se_side)
  );

  rff_perm u_perm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (se_valid),
    .se_q      (se_q),
    .f         (front_t'(se_side)),
    .mw        (cfg_r.mw),
    .mo        (cfg_r.mo),
    .out_valid (pm_valid),
    .out_data  (pm_data)
  );

  always_comb begin
    ma_s       = '0;
    ma_s.krw   = pm_data.krw;
    ma_s.kro   = pm_data.kro;
    ma_s.nw    = pm_data.nw;
    ma_s.undef = pm_data.undef;
    ma_s.clip  = pm_data.clip;
  end

  rff_int_div #(.NW(MNUM_W), .DW(VISC_W), .SW(MOBS_W)) u_mob_w (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pm_valid),
    .num       (pm_data.mnw),
    .den       (cfg_r.mw),
    .side      (ma_s),
    .out_valid (ma_valid),
    .quo       (ma_q),
    .side_out  (ma_side)
  );

  rff_int_div #(.NW(MNUM_W), .DW(VISC_W), .SW(PROD_W)) u_mob_o (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pm_valid),
    .num       (pm_data.mno),
    .den       (cfg_r.mo),
    .side      (pm_data.no),
    .out_valid (mb_valid),
    .quo       (mb_q),
    .side_out  (mb_side)
  );

  assign ma_d = mobs_t'(ma_side);

  // mobility sum and flow denominator
  always_comb begin
    mobs_t ms;
    ms             = mobs_t'(ma_side);
    mob_sum        = {1'b0, ma_q} + {1'b0, mb_q};
    tail_nxt       = '0;
    tail_nxt.clip  = ms.clip || (mob_sum > (MNUM_W + 1)'(MOB_MAX));
    tail_nxt.mob   = (mob_sum > (MNUM_W + 1)'(MOB_MAX)) ? MOB_MAX : mob_sum[MOB_W-1:0];
    tail_nxt.undef = ms.undef || ((ms.nw == '0) && (mb_side == '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mx_valid_r <= 1'b0;
    end else if (en) begin
      mx_valid_r <= ma_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_den_r      <= {1'b0, ma_d.nw} + {1'b0, mb_side};
      mx_nw_r       <= {1'b0, ma_d.nw};
      mx_no_r       <= {1'b0, mb_side};
      mx_kr_r.krw   <= ma_d.krw;
      mx_kr_r.kro   <= ma_d.kro;
      mx_tail_r     <= tail_nxt;
    end
  end

  rff_ratio_div #(.DW(DEN_W), .SW(KR_W)) u_fw_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (mx_valid_r),
    .num       (mx_nw_r),
    .den       (mx_den_r),
    .side      (mx_kr_r),
    .out_valid (ra_valid),
    .quo       (ra_q),
    .side_out  (ra_side)
  );

  rff_ratio_div #(.DW(DEN_W), .SW(TAIL_W)) u_fo_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (mx_valid_r),
    .num       (mx_no_r),
    .den       (mx_den_r),
    .side      (mx_tail_r),
    .out_valid (rb_valid),
    .quo       (rb_q),
    .side_out  (rb_side)
  );

  assign ra_s = kr_t'(ra_side);
  assign rb_s = tail_t'(rb_side);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ra_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_krw_r   <= ra_s.krw;
      out_kro_r   <= ra_s.kro;
      out_mob_r   <= rb_s.mob;
      out_fw_r    <= rb_s.undef ? '0 : ra_q;
      out_fo_r    <= rb_s.undef ? '0 : rb_q;
      out_undef_r <= rb_s.undef;
      out_clip_r  <= rb_s.clip;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_water_relperm       = out_krw_r;
  assign out_oil_relperm         = out_kro_r;
  assign out_total_mobility      = out_mob_r;
  assign out_water_flow_fraction = out_fw_r;
  assign out_oil_flow_fraction   = out_fo_r;
  assign out_undefined_flag      = out_undef_r;
  assign out_clipped_flag        = out_clip_r;

  a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    (ma_valid == mb_valid) && (ra_valid == rb_valid))
    else $error("divider lanes out of step");

  a_flows_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_undefined_flag |->
      (({1'b0, out_water_flow_fraction} + {1'b0, out_oil_flow_fraction}) == {1'b0, ONE}) ||
      (({1'b0, out_water_flow_fraction} + {1'b0, out_oil_flow_fraction}) ==
        ({1'b0, ONE} + (FX_W + 1)'(1))))
    else $error("fractional flows do not sum to one");

  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_undefined_flag |->
      (out_water_flow_fraction == '0) && (out_oil_flow_fraction == '0))
    else $error("undefined result carries nonzero flows");

  a_perm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_water_relperm <= ONE) && (out_oil_relperm <= ONE))
    else $error("relative permeability above one");

endmodule

// ----- rtl/core/rff_front.sv -----
// Input stage: clamps the saturation, forms both squares and the
// normalized-saturation operands. Depends on rff_pkg.
module rff_front import rff_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [FX_W-1:0] saturation,
  input  cfg_t            cfg,
  output logic            out_valid,
  output front_t          out_data
);

  logic              valid_r;
  front_t            data_r;
  front_t            data_nxt;
  logic [FX_W:0]     res_sum;
  logic [FX_W-1:0]   d;

  always_comb begin
    data_nxt       = '0;
    data_nxt.model = cfg.model;
    data_nxt.clip  = saturation > ONE;
    data_nxt.s     = data_nxt.clip ? ONE : saturation;
    data_nxt.c     = ONE - data_nxt.s;
    data_nxt.sq_s  = fx_mul(data_nxt.s, data_nxt.s);
    data_nxt.sq_c  = fx_mul(data_nxt.c, data_nxt.c);
    res_sum        = {1'b0, cfg.rw} + {1'b0, cfg.ro};
    d              = data_nxt.s - cfg.rw;
    data_nxt.undef = (cfg.model == MODEL_COREY) && (res_sum >= {1'b0, ONE});
    data_nxt.span  = ONE - res_sum[FX_W-1:0];
    data_nxt.se_num = d;
    if (data_nxt.s <= cfg.rw) begin
      data_nxt.se_sel = SE_ZERO;
    end else if (d >= data_nxt.span) begin
      data_nxt.se_sel = SE_ONE;
    end else begin
      data_nxt.se_sel = SE_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- rtl/core/rff_ratio_div.sv -----
// Pipelined rounded fraction divider, num <= den, one quotient bit per
// stage plus a rounding stage. Depends on rff_pkg.
module rff_ratio_div import rff_pkg::*; #(
  parameter int DW = FX_W,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [DW-1:0]   num,
  input  logic [DW-1:0]   den,
  input  logic [SW-1:0]   side,
  output logic            out_valid,
  output logic [FX_W-1:0] quo,
  output logic [SW-1:0]   side_out
);

  localparam int N = FRAC_BITS + 2;

  logic            v_r [N];
  logic [FX_W-1:0] q_r [N];
  logic [SW-1:0]   s_r [N];
  logic [DW-1:0]   r_r [N-1];
  logic [DW-1:0]   d_r [N-1];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [DW:0]     r2;
    logic [DW:0]     rs;
    logic            ge;
    logic [FX_W-1:0] q_nxt;
    logic [DW-1:0]   r_nxt;

    if (k == 0) begin : g_first
      always_comb begin
        r2    = {1'b0, num};
        rs    = r2 - {1'b0, den};
        ge    = r2 >= {1'b0, den};
        r_nxt = ge ? rs[DW-1:0] : r2[DW-1:0];
        q_nxt = FX_W'(ge);
      end
      always_ff @(posedge clk) begin
        if (en) begin
          r_r[k] <= r_nxt;
          d_r[k] <= den;
          q_r[k] <= q_nxt;
          s_r[k] <= side;
        end
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= in_valid;
        end
      end
    end else if (k < N - 1) begin : g_mid
      always_comb begin
        r2    = {r_r[k-1], 1'b0};
        rs    = r2 - {1'b0, d_r[k-1]};
        ge    = r2 >= {1'b0, d_r[k-1]};
        r_nxt = ge ? rs[DW-1:0] : r2[DW-1:0];
        q_nxt = {q_r[k-1][FX_W-2:0], ge};
      end
      always_ff @(posedge clk) begin
        if (en) begin
          r_r[k] <= r_nxt;
          d_r[k] <= d_r[k-1];
          q_r[k] <= q_nxt;
          s_r[k] <= s_r[k-1];
        end
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end else begin : g_round
      always_comb begin
        r2    = {r_r[k-1], 1'b0};
        rs    = '0;
        ge    = r2 >= {1'b0, d_r[k-1]};
        r_nxt = '0;
        q_nxt = q_r[k-1] + FX_W'(ge);
      end
      always_ff @(posedge clk) begin
        if (en) begin
          q_r[k] <= q_nxt;
          s_r[k] <= s_r[k-1];
        end
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign quo       = q_r[N-1];
  assign side_out  = s_r[N-1];

endmodule

// ----- rtl/core/rff_int_div.sv -----
// Pipelined restoring integer divider, floor(num/den), one quotient bit
// per stage. Depends on rff_pkg.
module rff_int_div import rff_pkg::*; #(
  parameter int NW = MNUM_W,
  parameter int DW = VISC_W,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic          out_valid,
  output logic [NW-1:0] quo,
  output logic [SW-1:0] side_out
);

  localparam int N = NW;

  logic          v_r [N];
  logic [NW-1:0] q_r [N];
  logic [SW-1:0] s_r [N];
  logic [DW-1:0] r_r [N-1];
  logic [DW-1:0] d_r [N-1];
  logic [NW-1:0] n_r [N-1];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [DW-1:0] rp;
    logic [DW-1:0] dp;
    logic [NW-1:0] qp;
    logic [NW-1:0] np;
    logic          vp;
    logic [SW-1:0] sp;
    logic [DW:0]   r2;
    logic [DW:0]   rs;
    logic          ge;

    if (k == 0) begin : g_src0
      assign rp = '0;
      assign dp = den;
      assign qp = '0;
      assign np = num;
      assign vp = in_valid;
      assign sp = side;
    end else begin : g_srcn
      assign rp = r_r[k-1];
      assign dp = d_r[k-1];
      assign qp = q_r[k-1];
      assign np = n_r[k-1];
      assign vp = v_r[k-1];
      assign sp = s_r[k-1];
    end

    always_comb begin
      r2 = {rp, np[NW-1-k]};
      rs = r2 - {1'b0, dp};
      ge = r2 >= {1'b0, dp};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= {qp[NW-2:0], ge};
        s_r[k] <= sp;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vp;
      end
    end

    if (k < N - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          r_r[k] <= ge ? rs[DW-1:0] : r2[DW-1:0];
          d_r[k] <= dp;
          n_r[k] <= np;
        end
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign quo       = q_r[N-1];
  assign side_out  = s_r[N-1];

endmodule

// ----- rtl/core/rff_perm.sv -----
// Two stages: model select and final squares for the permeabilities, then
// the viscosity products and mobility numerators. Depends on rff_pkg.
module rff_perm import rff_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [FX_W-1:0]   se_q,
  input  front_t            f,
  input  logic [VISC_W-1:0] mw,
  input  logic [VISC_W-1:0] mo,
  output logic              out_valid,
  output mid_t              out_data
);

  logic            v1_r;
  logic [FX_W-1:0] krw_r;
  logic [FX_W-1:0] kro_r;
  logic            undef_r;
  logic            clip_r;
  logic [FX_W-1:0] krw_nxt;
  logic [FX_W-1:0] kro_nxt;
  logic [FX_W-1:0] se;
  logic [FX_W-1:0] x;
  logic [FX_W-1:0] y1;
  logic [FX_W-1:0] y2;
  logic [FX_W-1:0] pa;
  logic [FX_W-1:0] pb;
  logic            v2_r;
  mid_t            mid_r;
  mid_t            mid_nxt;

  always_comb begin
    case (f.se_sel)
      SE_ZERO: se = '0;
      SE_ONE:  se = ONE;
      default: se = se_q;
    endcase
    if (f.model == MODEL_COREY) begin
      x  = se;
      y1 = ONE - se;
      y2 = ONE - se;
    end else begin
      x  = f.sq_s;
      y1 = f.sq_c;
      y2 = ONE - f.sq_s;
    end
    pa = fx_mul(x, x);
    pb = fx_mul(y1, y2);
    case (f.model)
      MODEL_LINEAR: begin
        krw_nxt = f.s;
        kro_nxt = f.c;
      end
      MODEL_QUAD: begin
        krw_nxt = f.sq_s;
        kro_nxt = f.sq_c;
      end
      MODEL_COREY: begin
        krw_nxt = f.undef ? '0 : pa;
        kro_nxt = f.undef ? '0 : pb;
      end
      default: begin
        krw_nxt = pa;
        kro_nxt = pb;
      end
    endcase
  end

  always_comb begin
    mid_nxt       = '0;
    mid_nxt.krw   = krw_r;
    mid_nxt.kro   = kro_r;
    mid_nxt.nw    = PROD_W'(krw_r) * PROD_W'(mo);
    mid_nxt.no    = PROD_W'(kro_r) * PROD_W'(mw);
    mid_nxt.mnw   = {krw_r, {VISC_FRAC{1'b0}}} + MNUM_W'(mw >> 1);
    mid_nxt.mno   = {kro_r, {VISC_FRAC{1'b0}}} + MNUM_W'(mo >> 1);
    mid_nxt.undef = undef_r;
    mid_nxt.clip  = clip_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      krw_r   <= krw_nxt;
      kro_r   <= kro_nxt;
      undef_r <= f.undef;
      clip_r  <= f.clip;
      mid_r   <= mid_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_data  = mid_r;

endmodule

// ----- bench/relperm_fractional_flow_core_tb.sv -----
// Self-checking bench for relperm_fractional_flow_core: random and directed saturation
// words, checked field by field against an in-bench predictor across several register settings.
// Depends on rff_pkg and the core RTL.
module relperm_fractional_flow_core_tb;
  import rff_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 80;
  localparam int RAND_PHASES = 12;
  localparam int RAND_ITEMS  = 110;

  // indexes past the register list, writes are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

  typedef struct {
    logic [15:0] krw;
    logic [15:0] kro;
    logic [23:0] mob;
    logic [15:0] fw;
    logic [15:0] fo;
    logic        undef;
    logic        clip;
  } flow_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [FX_W-1:0]      in_saturation = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [FX_W-1:0]      out_water_relperm;
  logic [FX_W-1:0]      out_oil_relperm;
  logic [MOB_W-1:0]     out_total_mobility;
  logic [FX_W-1:0]      out_water_flow_fraction;
  logic [FX_W-1:0]      out_oil_flow_fraction;
  logic                 out_undefined_flag;
  logic                 out_clipped_flag;

  relperm_fractional_flow_core dut (.*);

  always #5 clk = ~clk;

  // register shadow
  perm_model_t sh_model = MODEL_LINEAR;
  logic [15:0] sh_rw = 16'd0, sh_ro = 16'd0, sh_mw = 16'd256, sh_mo = 16'd256;

  logic [15:0] sat_pending[$];
  flow_word_t  flow_expected[$];
  int  words_in = 0, words_out = 0, mismatches = 0;
  int  idle_cycles = 0;
  int  undef_seen = 0, clip_seen = 0;
  bit  in_taken = 0, calm = 0, hold_done = 0;
  int  send_gap = 0, recv_gap = 0, hold_cnt = 0;

  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    return (a * b + 64'd16384) >> 15;
  endfunction

  function automatic logic [63:0] qratio(logic [63:0] num, logic [63:0] den);
    logic [63:0] q, r;
    q = 0;
    r = num;
    if (r >= den) begin
      q = 1;
      r -= den;
    end
    for (int i = 0; i < 15; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r -= den;
        q |= 1;
      end
    end
    r = r << 1;
    if (r >= den) q += 1;
    return q;
  endfunction

  function automatic flow_word_t predict_flow(logic [15:0] sat_in);
    flow_word_t  w;
    logic [63:0] s, c, krw, kro, mw, mo, s2, span, se, ce, mob, nw, no, den;
    w = '{default: '0};
    s = sat_in;
    krw = 0;
    kro = 0;
    if (s > 64'd32768) begin
      s = 64'd32768;
      w.clip = 1;
    end
    c = 64'd32768 - s;
    mw = (sh_mw == 0) ? 64'd1 : 64'(sh_mw);
    mo = (sh_mo == 0) ? 64'd1 : 64'(sh_mo);
    case (sh_model)
      MODEL_LINEAR: begin
        krw = s;
        kro = c;
      end
      MODEL_QUAD: begin
        krw = qmul(s, s);
        kro = qmul(c, c);
      end
      MODEL_COREY: begin
        if (64'(sh_rw) + 64'(sh_ro) >= 64'd32768) begin
          w.undef = 1;
        end else begin
          span = 64'd32768 - sh_rw - sh_ro;
          if (s <= sh_rw) se = 0;
          else if (s - sh_rw >= span) se = 64'd32768;
          else se = qratio(s - sh_rw, span);
          ce = 64'd32768 - se;
          krw = qmul(se, se);
          kro = qmul(ce, ce);
        end
      end
      default: begin
        s2 = qmul(s, s);
        krw = qmul(s2, s2);
        kro = qmul(qmul(c, c), 64'd32768 - s2);
      end
    endcase
    mob = ((krw << 8) + (mw >> 1)) / mw + ((kro << 8) + (mo >> 1)) / mo;
    if (mob > 64'hFFFFFF) begin
      mob = 64'hFFFFFF;
      w.clip = 1;
    end
    nw = krw * mo;
    no = kro * mw;
    den = nw + no;
    if (den == 0) begin
      w.undef = 1;
    end else begin
      w.fw = 16'(qratio(nw, den));
      w.fo = 16'(qratio(no, den));
    end
    w.krw = 16'(krw);
    w.kro = 16'(kro);
    w.mob = 24'(mob);
    return w;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // sender
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (sat_pending.size() > 0) begin
        in_saturation <= sat_pending.pop_front();
        in_valid <= 1'b1;
        send_gap <= (!calm && $urandom_range(0, 3) == 0) ? gap_len() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off to back the pipe up
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && words_in >= 300) begin
        hold_done <= 1;
        hold_cnt <= 400;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        recv_gap <= gap_len() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // acceptance, checking, watchdog
  always @(posedge clk) begin
    flow_word_t e;
    bit accepted;
    accepted = 0;
    in_taken <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      flow_expected.push_back(predict_flow(in_saturation));
      words_in <= words_in + 1;
      accepted = 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      accepted = 1;
      words_out <= words_out + 1;
      if (flow_expected.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected output word at %0t", $realtime);
      end else begin
        e = flow_expected.pop_front();
        undef_seen <= undef_seen + e.undef;
        clip_seen <= clip_seen + e.clip;
        if (out_water_relperm !== e.krw || out_oil_relperm !== e.kro ||
            out_total_mobility !== e.mob || out_water_flow_fraction !== e.fw ||
            out_oil_flow_fraction !== e.fo || out_undefined_flag !== e.undef ||
            out_clipped_flag !== e.clip) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("word %0d: exp krw=%0d kro=%0d mob=%0d fw=%0d fo=%0d u=%0b c=%0b",
                     words_out, e.krw, e.kro, e.mob, e.fw, e.fo, e.undef, e.clip,
                     "\n        got krw=%0d kro=%0d mob=%0d fw=%0d fo=%0d u=%0b c=%0b",
                     out_water_relperm, out_oil_relperm, out_total_mobility,
                     out_water_flow_fraction, out_oil_flow_fraction,
                     out_undefined_flag, out_clipped_flag);
        end
      end
    end
    if (accepted) idle_cycles <= 0;
    else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_PERM_MODEL: sh_model = perm_model_t'(val[1:0]);
      CFG_RES_WATER:  sh_rw = val;
      CFG_RES_OIL:    sh_ro = val;
      CFG_VISC_WATER: sh_mw = val;
      CFG_VISC_OIL:   sh_mo = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_regs(perm_model_t m, logic [15:0] rw, logic [15:0] ro,
                           logic [15:0] mw, logic [15:0] mo);
    write_reg(CFG_PERM_MODEL, 16'(m));
    write_reg(CFG_RES_WATER, rw);
    write_reg(CFG_RES_OIL, ro);
    write_reg(CFG_VISC_WATER, mw);
    write_reg(CFG_VISC_OIL, mo);
  endtask

  task automatic drain();
    while (sat_pending.size() > 0 || in_valid || flow_expected.size() > 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_res();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'($urandom_range(0, 32768));
      default: return 16'($urandom_range(0, 12000));
    endcase
  endfunction

  function automatic logic [15:0] pick_visc();
    case ($urandom_range(0, 7))
      0: return 16'd1;
      1: return 16'd65535;
      2: return 16'd0;
      3: return 16'd256;
      4: return 16'($urandom_range(1, 2048));
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_sat();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'(32768 - $urandom_range(0, 4));
      2: return 16'(32768 + $urandom_range(0, 4));
      3: return 16'($urandom_range(0, 4));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  initial begin
    logic [15:0] edge_sats[$];
    edge_sats = '{16'd0, 16'd1, 16'd16384, 16'd32767, 16'd32768, 16'd32769, 16'd65535};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // reset values, linear model
    foreach (edge_sats[i]) sat_pending.push_back(edge_sats[i]);
    drain();
    write_reg(CFG_UNMAPPED_LO, 16'd3);
    write_reg(CFG_UNMAPPED_HI, 16'hFFFF);
    load_regs(MODEL_QUAD, 16'd0, 16'd0, 16'd1, 16'd65535);
    foreach (edge_sats[i]) if (i < 5) sat_pending.push_back(edge_sats[i]);
    drain();
    load_regs(MODEL_COREY, 16'd3277, 16'd6554, 16'd0, 16'd512);
    sat_pending = '{16'd0, 16'd3277, 16'd3278, 16'd26214, 16'd32768};
    drain();
    load_regs(MODEL_COREY, 16'd16384, 16'd16384, 16'd256, 16'd256);
    sat_pending = '{16'd100, 16'd30000};
    drain();
    load_regs(MODEL_QUARTIC, 16'd0, 16'd0, 16'd65535, 16'd1);
    sat_pending = '{16'd0, 16'd1, 16'd23170, 16'd32768};
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      calm = (p % 4 == 3);
      load_regs(perm_model_t'($urandom_range(0, 3)), pick_res(), pick_res(),
                pick_visc(), pick_visc());
      for (int i = 0; i < RAND_ITEMS; i++) sat_pending.push_back(pick_sat());
      drain();
    end
    calm = 0;

    $display("%0d words in, %0d words out over %0d register settings (%0d random);",
             words_in, words_out, RAND_PHASES + 5, RAND_PHASES);
    $display("  %0d undefined and %0d clipped results, %0d mismatches",
             undef_seen, clip_seen, mismatches);
    if (mismatches == 0 && flow_expected.size() == 0 && words_in == words_out)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
